@@ hdl/ksm_pkg.sv @@
// ----------------------------------------------------------------------------
// ksm_pkg
// shared types, codes and sizes of the k-slot distributed mutex node
// ----------------------------------------------------------------------------
package ksm_pkg;

    localparam int MAX_NODES = 16;
    localparam int TIME_BITS = 16;
    localparam int DEFER_CAP = MAX_NODES - 1;

    localparam int ID_W    = 4;                       // node identifier field
    localparam int CNT_W   = $clog2(MAX_NODES + 1);   // node counts and walk index
    localparam int QADDR_W = $clog2(MAX_NODES);       // deferred queue address
    localparam int ACK_W   = 5;
    localparam int NC_W    = 5;
    localparam int SLOT_W  = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOCAL_REQ = 2'd0,
        KIND_LOCAL_REL = 2'd1,
        KIND_REQ_RCVD  = 2'd2,
        KIND_ACK_RCVD  = 2'd3
    } evt_kind_t;

    typedef enum logic [KIND_W-1:0] {
        MSG_REQ   = 2'd0,
        MSG_REL   = 2'd1,
        MSG_ACK   = 2'd2,
        MSG_GRANT = 2'd3
    } msg_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MY_NODE    = 2'd0,
        CFG_NODE_COUNT = 2'd1,
        CFG_SLOTS      = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_INC = 1'b0,
        OP_CMP = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [ID_W-1:0]   my_node;
        logic [NC_W-1:0]   node_count;
        logic [SLOT_W-1:0] slots;
    } cfg_t;

    typedef struct packed {
        alu_op_t              op;
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] sum;
        logic                 lt;
        logic                 eq;
    } alu_rsp_t;

    typedef struct packed {
        logic               en;
        logic [QADDR_W-1:0] addr;
        logic [ID_W-1:0]    data;
    } q_wr_t;

endpackage

@@ hdl/ksm_evt_if.sv @@
// ----------------------------------------------------------------------------
// ksm_evt_if
// event channel into the mutex node: local requests, releases, messages
// ----------------------------------------------------------------------------
interface ksm_evt_if
    import ksm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      src_node;
    logic [TIME_BITS-1:0] msg_ts;

    modport source (output valid, kind, src_node, msg_ts, input ready);
    modport sink   (input valid, kind, src_node, msg_ts, output ready);
endinterface

@@ hdl/ksm_msg_if.sv @@
// ----------------------------------------------------------------------------
// ksm_msg_if
// message channel out of the mutex node: outgoing messages and grants
// ----------------------------------------------------------------------------
interface ksm_msg_if
    import ksm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    msg_kind;
    logic [ID_W-1:0]      dest_node;
    logic [TIME_BITS-1:0] out_ts;
    logic                 last;

    modport source (output valid, msg_kind, dest_node, out_ts, last, input ready);
    modport sink   (input valid, msg_kind, dest_node, out_ts, last, output ready);
endinterface

@@ hdl/ksm_alu.sv @@
// ----------------------------------------------------------------------------
// ksm_alu
// shared increment / compare unit: one subtractor serves every step
// ----------------------------------------------------------------------------
module ksm_alu
    import ksm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [TIME_BITS:0] b_eff;
    logic [TIME_BITS:0] diff;

    // increment is a minus minus one
    assign b_eff = (req.op == OP_INC) ? {(TIME_BITS + 1){1'b1}} : {1'b0, req.b};
    assign diff  = {1'b0, req.a} - b_eff;

    assign rsp.sum = diff[TIME_BITS-1:0];
    assign rsp.lt  = diff[TIME_BITS];
    assign rsp.eq  = (diff == '0);

endmodule

@@ hdl/ksm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ksm_ctrl
// sequencer of the mutex node: protocol state, message walk, output register
// ----------------------------------------------------------------------------
module ksm_ctrl
    import ksm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    ksm_evt_if.sink           evt,
    ksm_msg_if.source         msg,
    output alu_req_t          alu_req,
    input  alu_rsp_t          alu_rsp,
    output q_wr_t             q_wr,
    output logic [QADDR_W-1:0] q_rd_addr,
    input  logic [ID_W-1:0]   q_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_BCAST,
        S_DRAIN_RD,
        S_DRAIN,
        S_CMP_OWN,
        S_CMP_CLK,
        S_ANSWER,
        S_ACK_INC,
        S_THRESH,
        S_GRANT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_HOLD = 2'd2
    } phase_t;

    state_t               state_reg;
    phase_t               phase_reg;
    evt_kind_t            kind_reg;
    logic [ID_W-1:0]      src_reg;
    logic [TIME_BITS-1:0] ts_reg;
    logic [TIME_BITS-1:0] lamport_reg;
    logic [TIME_BITS-1:0] own_reg;
    logic [ACK_W-1:0]     ack_reg;
    logic [CNT_W-1:0]     dcount_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 ack_now_reg;

    logic                 out_valid_reg;
    msg_kind_t            out_kind_reg;
    logic [ID_W-1:0]      out_dest_reg;
    logic [TIME_BITS-1:0] out_ts_reg;
    logic                 out_last_reg;

    logic [CNT_W-1:0]     lim;
    logic [CNT_W-1:0]     idx_nxt;
    logic [CNT_W:0]       idx_nxt2;
    logic                 is_self;
    logic                 more_peers;
    logic                 out_free;
    logic                 emit;
    msg_kind_t            e_kind;
    logic [ID_W-1:0]      e_dest;
    logic [TIME_BITS-1:0] e_ts;
    logic                 e_last;
    logic [ACK_W:0]       ack_plus_slots;

    assign lim = (cfg.node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(cfg.node_count);
    assign idx_nxt  = idx_reg + 1'b1;
    assign idx_nxt2 = {1'b0, idx_nxt} + 1'b1;
    assign is_self  = (idx_reg == CNT_W'(cfg.my_node));
    // another peer follows unless the next index is past the end, or is this
    // node and the one after it is past the end
    assign more_peers = (idx_nxt < lim) &&
                        !((idx_nxt == CNT_W'(cfg.my_node)) && (idx_nxt2 >= (CNT_W+1)'(lim)));

    assign out_free = !out_valid_reg || msg.ready;
    assign ack_plus_slots = (ACK_W+1)'(ack_reg) + (ACK_W+1)'(cfg.slots);

    assign evt.ready     = (state_reg == S_IDLE);
    assign msg.valid     = out_valid_reg;
    assign msg.msg_kind  = out_kind_reg;
    assign msg.dest_node = out_dest_reg;
    assign msg.out_ts    = out_ts_reg;
    assign msg.last      = out_last_reg;

    assign q_rd_addr = idx_reg[QADDR_W-1:0];
    assign q_wr.en   = (state_reg == S_ANSWER) && !ack_now_reg &&
                       (dcount_reg < CNT_W'(DEFER_CAP));
    assign q_wr.addr = dcount_reg[QADDR_W-1:0];
    assign q_wr.data = src_reg;

    // operands of the shared unit per step
    always_comb
    begin
        alu_req.op = OP_CMP;
        alu_req.a  = ts_reg;
        alu_req.b  = own_reg;
        unique case (state_reg)
            S_INC:
            begin
                alu_req.op = OP_INC;
                alu_req.a  = lamport_reg;
            end
            S_CMP_CLK:
            begin
                alu_req.a = lamport_reg;
                alu_req.b = ts_reg;
            end
            S_ACK_INC:
            begin
                alu_req.op = OP_INC;
                alu_req.a  = TIME_BITS'(ack_reg);
            end
            S_THRESH:
            begin
                alu_req.a = TIME_BITS'(ack_plus_slots);
                alu_req.b = TIME_BITS'(cfg.node_count);
            end
            default:
            begin
                alu_req.op = OP_CMP;
            end
        endcase
    end

    // result offered to the output register
    always_comb
    begin
        emit   = 1'b0;
        e_kind = MSG_ACK;
        e_dest = src_reg;
        e_ts   = '0;
        e_last = 1'b1;
        unique case (state_reg)
            S_BCAST:
            begin
                emit   = (idx_reg < lim) && !is_self;
                e_kind = (kind_reg == KIND_LOCAL_REL) ? MSG_REL : MSG_REQ;
                e_dest = idx_reg[ID_W-1:0];
                e_ts   = (kind_reg == KIND_LOCAL_REL) ? '0 : own_reg;
                e_last = !more_peers &&
                         ((kind_reg != KIND_LOCAL_REL) || (dcount_reg == '0));
            end
            S_DRAIN:
            begin
                emit   = 1'b1;
                e_dest = q_rd_data;
                e_last = (idx_nxt == dcount_reg);
            end
            S_ANSWER:
            begin
                emit = ack_now_reg;
            end
            S_GRANT:
            begin
                emit   = 1'b1;
                e_kind = MSG_GRANT;
                e_dest = '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            kind_reg      <= KIND_LOCAL_REQ;
            src_reg       <= '0;
            ts_reg        <= '0;
            lamport_reg   <= '0;
            own_reg       <= '0;
            ack_reg       <= '0;
            dcount_reg    <= '0;
            idx_reg       <= '0;
            ack_now_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= MSG_REQ;
            out_dest_reg  <= '0;
            out_ts_reg    <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= e_kind;
                out_dest_reg  <= e_dest;
                out_ts_reg    <= e_ts;
                out_last_reg  <= e_last;
            end
            else if (msg.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (evt.valid)
                    begin
                        kind_reg <= evt_kind_t'(evt.kind);
                        src_reg  <= evt.src_node;
                        ts_reg   <= evt.msg_ts;
                        idx_reg  <= '0;
                        unique case (evt_kind_t'(evt.kind))
                            KIND_LOCAL_REQ: state_reg <= S_INC;
                            KIND_LOCAL_REL: state_reg <= S_BCAST;
                            KIND_REQ_RCVD:  state_reg <= S_CMP_OWN;
                            KIND_ACK_RCVD:
                                state_reg <= (phase_reg == PH_WAIT) ? S_ACK_INC : S_IDLE;
                        endcase
                    end
                end
                S_INC:
                begin
                    lamport_reg <= alu_rsp.sum;
                    own_reg     <= alu_rsp.sum;
                    ack_reg     <= '0;
                    phase_reg   <= PH_WAIT;
                    state_reg   <= S_BCAST;
                end
                S_BCAST:
                begin
                    if (idx_reg >= lim)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (kind_reg == KIND_LOCAL_REL) ? S_DRAIN_RD : S_IDLE;
                    end
                    else if (is_self || out_free)
                    begin
                        idx_reg <= idx_nxt;
                    end
                end
                S_DRAIN_RD:
                begin
                    if (idx_reg >= dcount_reg)
                    begin
                        dcount_reg <= '0;
                        phase_reg  <= PH_IDLE;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (out_free)
                    begin
                        idx_reg   <= idx_nxt;
                        state_reg <= S_DRAIN_RD;
                    end
                end
                S_CMP_OWN:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        ack_now_reg <= alu_rsp.lt || (alu_rsp.eq && (src_reg < cfg.my_node));
                    end
                    else
                    begin
                        ack_now_reg <= (phase_reg == PH_IDLE);
                    end
                    state_reg <= S_CMP_CLK;
                end
                S_CMP_CLK:
                begin
                    if (alu_rsp.lt)
                    begin
                        lamport_reg <= ts_reg;
                    end
                    state_reg <= S_ANSWER;
                end
                S_ANSWER:
                begin
                    if (ack_now_reg)
                    begin
                        if (out_free)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        if (q_wr.en)
                        begin
                            dcount_reg <= dcount_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_ACK_INC:
                begin
                    if (ack_reg != '1)
                    begin
                        ack_reg <= alu_rsp.sum[ACK_W-1:0];
                    end
                    state_reg <= S_THRESH;
                end
                S_THRESH:
                begin
                    if (!alu_rsp.lt)
                    begin
                        phase_reg <= PH_HOLD;
                        state_reg <= S_GRANT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_GRANT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/k_slot_distributed_mutex_node_unit.sv @@
// ----------------------------------------------------------------------------
// k_slot_distributed_mutex_node_unit
// one node of a k-holder ricart-agrawala mutual exclusion with lamport clock
// ----------------------------------------------------------------------------
// the node takes one event at a time on evt and answers with a burst of
// messages on msg, the final one flagged by last. a local request bumps
// the clock and walks the node indices below min(node_count, 16); a local
// release walks the same indices, then serves each deferred node (a
// registered queue read and the send); a received request compares stamps
// and acks or defers; a received ack while waiting is counted and the grant
// threshold checked. the clock increment, timestamp compares, ack count and
// grant threshold compare go through a single shared subtract unit, one
// step a cycle, and the message walk emits at most one message a cycle. evt
// is not ready while an event is in work; a stalled msg side holds the
// walk. the output register lets the next event be taken while the final
// message still waits. configuration is written on cfg_we with cfg_index
// and cfg_data; the user must do so only while the node is idle, which the
// block does not enforce; an index beyond the register list is ignored.
// ----------------------------------------------------------------------------
module k_slot_distributed_mutex_node_unit
    import ksm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ksm_evt_if.sink               evt,
    ksm_msg_if.source             msg
);

    // configuration registers
    logic [ID_W-1:0]   my_node_reg;
    logic [NC_W-1:0]   node_count_reg;
    logic [SLOT_W-1:0] slots_reg;
    cfg_t              cfg;

    // deferred request queue, filled in arrival order, read back in that order through a registered port
    logic [ID_W-1:0]    defer_mem [MAX_NODES];
    logic [ID_W-1:0]    q_rd_data_reg;
    logic [QADDR_W-1:0] q_rd_addr;
    q_wr_t              q_wr;

    // shared arithmetic unit
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_node_reg    <= '0;
            node_count_reg <= NC_W'(2);
            slots_reg      <= SLOT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_MY_NODE:    my_node_reg    <= cfg_data[ID_W-1:0];
                CFG_NODE_COUNT: node_count_reg <= cfg_data[NC_W-1:0];
                CFG_SLOTS:      slots_reg      <= cfg_data[SLOT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.my_node    = my_node_reg;
    assign cfg.node_count = node_count_reg;
    assign cfg.slots      = slots_reg;

    // queue storage: no reset, only entries below the fill count are sent
    always_ff @(posedge clk)
    begin
        if (q_wr.en)
        begin
            defer_mem[q_wr.addr] <= q_wr.data;
        end
        q_rd_data_reg <= defer_mem[q_rd_addr];
    end

    ksm_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    ksm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .evt       (evt),
        .msg       (msg),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .q_wr      (q_wr),
        .q_rd_addr (q_rd_addr),
        .q_rd_data (q_rd_data_reg)
    );

endmodule

@@ tb/ksm_scoreboard.sv @@
// ----------------------------------------------------------------------------
// ksm_scoreboard
// watches the event and message channels of the mutex node, keeps its own
// copy of the node state, and checks every outgoing message in order
// ----------------------------------------------------------------------------
module ksm_scoreboard
    import ksm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ksm_evt_if                    evt,
    ksm_msg_if                    msg,
    output int                    mismatches,
    output int                    outstanding,
    output logic [TIME_BITS-1:0]  own_stamp
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAITING = 2'd1,
        PH_HOLDING = 2'd2
    } node_phase_t;

    typedef struct packed {
        msg_kind_t            kind;
        logic [ID_W-1:0]      dest;
        logic [TIME_BITS-1:0] ts;
        logic                 last;
    } node_msg_t;

    node_phase_t          node_phase;
    logic [TIME_BITS-1:0] clock_now;
    logic [TIME_BITS-1:0] req_time;
    logic [ACK_W-1:0]     acks;
    logic [ID_W-1:0]      waiters[$];
    cfg_t                 cfg;
    node_msg_t            burst[$];
    node_msg_t            due_msgs[$];

    task automatic flag_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic emit(msg_kind_t k, logic [ID_W-1:0] d, logic [TIME_BITS-1:0] ts);
        node_msg_t m;
        m.kind = k;
        m.dest = d;
        m.ts   = ts;
        m.last = 1'b0;
        burst.push_back(m);
    endtask

    // one message to every participating node except this one
    task automatic send_to_peers(msg_kind_t k, logic [TIME_BITS-1:0] ts);
        int lim;
        lim = (int'(cfg.node_count) < MAX_NODES) ? int'(cfg.node_count) : MAX_NODES;
        for (int i = 0; i < lim; i++)
        begin
            if (i != int'(cfg.my_node))
                emit(k, ID_W'(i), ts);
        end
    endtask

    task automatic advance_node(evt_kind_t k, logic [ID_W-1:0] src,
                                logic [TIME_BITS-1:0] ts);
        logic      ack_now;
        int        need;
        node_msg_t m;
        burst.delete();
        case (k)
            KIND_LOCAL_REQ:
            begin
                clock_now  = clock_now + 1'b1;
                req_time   = clock_now;
                acks       = '0;
                node_phase = PH_WAITING;
                send_to_peers(MSG_REQ, req_time);
            end
            KIND_LOCAL_REL:
            begin
                send_to_peers(MSG_REL, '0);
                foreach (waiters[i])
                    emit(MSG_ACK, waiters[i], '0);
                waiters.delete();
                node_phase = PH_IDLE;
            end
            KIND_REQ_RCVD:
            begin
                if (node_phase == PH_WAITING)
                    ack_now = (ts < req_time) || (ts == req_time && src < cfg.my_node);
                else
                    ack_now = (node_phase == PH_IDLE);
                if (ts > clock_now)
                    clock_now = ts;
                if (ack_now)
                    emit(MSG_ACK, src, '0);
                else if (waiters.size() < DEFER_CAP)
                    waiters.push_back(src);
            end
            default:
            begin
                if (node_phase == PH_WAITING)
                begin
                    if (acks != '1)
                        acks++;
                    need = int'(cfg.node_count) - int'(cfg.slots);
                    if (int'(acks) >= need)
                    begin
                        node_phase = PH_HOLDING;
                        emit(MSG_GRANT, '0, '0);
                    end
                end
            end
        endcase
        foreach (burst[i])
        begin
            m = burst[i];
            m.last = (i == burst.size() - 1);
            due_msgs.push_back(m);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        node_msg_t want;
        if (!rst_n)
        begin
            node_phase     = PH_IDLE;
            clock_now      = '0;
            req_time       = '0;
            acks           = '0;
            cfg.my_node    = '0;
            cfg.node_count = NC_W'(2);
            cfg.slots      = SLOT_W'(1);
            waiters.delete();
            due_msgs.delete();
            mismatches     = 0;
        end
        else
        begin
            // outputs first: a message can never belong to an event taken at this edge
            if (msg.valid && msg.ready)
            begin
                if (due_msgs.size() == 0)
                    flag_mismatch($sformatf("unexpected message kind %0d dest %0d",
                                            msg.msg_kind, msg.dest_node));
                else
                begin
                    want = due_msgs.pop_front();
                    if (msg.msg_kind !== want.kind)
                        flag_mismatch($sformatf("msg_kind got %0d want %0d",
                                                msg.msg_kind, want.kind));
                    if (msg.dest_node !== want.dest)
                        flag_mismatch($sformatf("dest_node got %0d want %0d",
                                                msg.dest_node, want.dest));
                    if (msg.out_ts !== want.ts)
                        flag_mismatch($sformatf("out_ts got %0d want %0d",
                                                msg.out_ts, want.ts));
                    if (msg.last !== want.last)
                        flag_mismatch($sformatf("last got %0b want %0b",
                                                msg.last, want.last));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MY_NODE:    cfg.my_node    = cfg_data[ID_W-1:0];
                    CFG_NODE_COUNT: cfg.node_count = cfg_data[NC_W-1:0];
                    CFG_SLOTS:      cfg.slots      = cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (evt.valid && evt.ready)
                advance_node(evt_kind_t'(evt.kind), evt.src_node, evt.msg_ts);
        end
        outstanding = due_msgs.size();
        own_stamp   = req_time;
    end

endmodule

@@ tb/tb_k_slot_distributed_mutex_node_unit.sv @@
// ----------------------------------------------------------------------------
// tb_k_slot_distributed_mutex_node_unit
// drives the mutex node with directed and random event streams under several
// node configurations, with random stalls on both channels; the scoreboard
// beside the node checks every message and the top gives the verdict
// ----------------------------------------------------------------------------
module tb_k_slot_distributed_mutex_node_unit;
    import ksm_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ksm_evt_if evt_ch ();
    ksm_msg_if msg_ch ();

    int                   mismatches;
    int                   outstanding;
    logic [TIME_BITS-1:0] own_stamp;

    // request handshake seen at the last rising edge, read by the driver at the
    // falling edge
    logic evt_taken;

    int   sent_count       = 0;
    int   long_holds_asked = 0;   // bumped by stimulus, served by the receiver
    logic steady           = 1'b0; // final stretch: no idling on either side

    // configuration currently written, used only to shape stimulus
    int cur_nc    = 2;
    int cur_slots = 1;

    k_slot_distributed_mutex_node_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_ch),
        .msg       (msg_ch)
    );

    ksm_scoreboard u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .evt         (evt_ch),
        .msg         (msg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .own_stamp   (own_stamp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the node hangs
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
        evt_taken <= evt_ch.valid && evt_ch.ready;

    // offer one request and hold it until the node takes it; called at a
    // falling edge, returns at a falling edge with valid possibly still high
    task automatic offer(evt_kind_t k, logic [ID_W-1:0] src, logic [TIME_BITS-1:0] ts);
        evt_ch.valid    <= 1'b1;
        evt_ch.kind     <= k;
        evt_ch.src_node <= src;
        evt_ch.msg_ts   <= ts;
        do
            @(negedge clk);
        while (!evt_taken);
        sent_count++;
        // random idle burst on the sending side
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // stop offering, let every expected message drain, then give the node
    // time to finish any event that sends nothing
    task automatic settle();
        evt_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
    endtask

    // writes all three registers back to back; only called while idle
    task automatic configure(int my, int nc, int sl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MY_NODE;
        cfg_data  <= CFG_DATA_W'(my);
        @(negedge clk);
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= CFG_DATA_W'(nc);
        @(negedge clk);
        cfg_index <= CFG_SLOTS;
        cfg_data  <= CFG_DATA_W'(sl);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_nc    = nc;
        cur_slots = sl;
    endtask

    // stamps around our own request time hit the tie-break and both orderings
    function automatic logic [TIME_BITS-1:0] near_stamp(logic [TIME_BITS-1:0] base);
        case ($urandom_range(0, 5))
            0:       return base - 1'b1;
            1, 2:    return base;
            3:       return base + 1'b1;
            4:       return TIME_BITS'($urandom);
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // mostly participating nodes, sometimes any id
    function automatic logic [ID_W-1:0] pick_src();
        if ($urandom_range(0, 3) == 0)
            return ID_W'($urandom);
        return ID_W'($urandom_range(0, cur_nc - 1));
    endfunction

    // one request / ack / grant / release cycle with random traffic mixed in;
    // a few rounds are cut short and release before the grant
    task automatic mutex_round();
        int need;
        int got;
        int extra;
        offer(KIND_LOCAL_REQ, pick_src(), TIME_BITS'($urandom));
        need = cur_nc - cur_slots;
        if (need < 1)
            need = 1;
        if ($urandom_range(0, 7) == 0)
            need = $urandom_range(0, need - 1);
        got = 0;
        while (got < need)
        begin
            if ($urandom_range(0, 2) == 0)
                offer(KIND_REQ_RCVD, pick_src(), near_stamp(own_stamp));
            else
            begin
                offer(KIND_ACK_RCVD, pick_src(), TIME_BITS'($urandom));
                got++;
            end
        end
        // while holding: requests from others get deferred, stray acks ignored
        extra = $urandom_range(0, 4);
        repeat (extra)
        begin
            if ($urandom_range(0, 4) == 0)
                offer(KIND_ACK_RCVD, pick_src(), TIME_BITS'($urandom));
            else
                offer(KIND_REQ_RCVD, pick_src(), near_stamp(own_stamp));
        end
        offer(KIND_LOCAL_REL, pick_src(), TIME_BITS'($urandom));
    endtask

    // receiver: random ready pattern, one long hold-off per request from the
    // stimulus, and always ready in the final stretch
    initial
    begin : receiver
        int hold;
        int long_holds_done;
        long_holds_done = 0;
        msg_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_holds_asked != long_holds_done)
            begin
                // long stall so the node backs up and stops taking requests
                msg_ch.ready <= 1'b0;
                hold = 400;
                long_holds_done++;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                msg_ch.ready <= 1'b0;
                hold = $urandom_range(1, 8);
            end
            else
            begin
                msg_ch.ready <= 1'b1;
                hold = steady ? 1 : $urandom_range(1, 16);
            end
            repeat (hold) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int phase_end;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_MY_NODE;
        cfg_data        = '0;
        evt_ch.valid    = 1'b0;
        evt_ch.kind     = KIND_LOCAL_REQ;
        evt_ch.src_node = '0;
        evt_ch.msg_ts   = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: 16 nodes, 15 slots, so the first ack grants entry
        configure(5, 16, 15);
        offer(KIND_ACK_RCVD, 4'd1, '0);          // ack while idle is dropped
        offer(KIND_REQ_RCVD, 4'd0, '1);          // idle: acked, clock jumps to the top
        offer(KIND_LOCAL_REQ, 4'd15, '0);        // clock wraps, requests carry stamp 0
        offer(KIND_REQ_RCVD, 4'd3, '0);          // same stamp, lower id: acked
        offer(KIND_REQ_RCVD, 4'd9, '0);          // same stamp, higher id: deferred
        offer(KIND_REQ_RCVD, 4'd2, 16'd1);       // later stamp: deferred
        offer(KIND_ACK_RCVD, 4'd4, '1);          // first ack grants
        offer(KIND_ACK_RCVD, 4'd6, '0);          // ack while holding is ignored
        // fill the deferred queue while holding; the last one finds it full
        for (int i = 0; i < 14; i++)
            offer(KIND_REQ_RCVD, ID_W'(15 - i), TIME_BITS'($urandom));
        offer(KIND_LOCAL_REL, '0, '0);           // 15 releases then 15 deferred acks
        offer(KIND_LOCAL_REL, '1, '1);           // release while idle still broadcasts

        // random phases, each under its own configuration
        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0:       configure(15, 2, 15);  // own id outside the group, threshold below zero
                1:       configure(0, 16, 1);   // widest group, fifteen acks needed
                default: configure($urandom_range(0, 15), $urandom_range(2, 16),
                                   $urandom_range(1, 15));
            endcase
            if (p == 2)
                long_holds_asked <= long_holds_asked + 1;
            if (p == 5)
                steady <= 1'b1;
            phase_end = sent_count + 34;
            while (sent_count < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    offer(evt_kind_t'($urandom_range(0, 3)), ID_W'($urandom),
                          TIME_BITS'($urandom));
                else
                    mutex_round();
            end
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
